// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the session table controller
// Implication checks with an asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define TST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("session table assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define TST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("session table assertion failed");

`endif

// ===== sv/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg
// Shared constants, opcodes and control types of the timed session table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

	// Table geometry
	localparam int SLOTS      = 4;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OUT_SLOT_W = 2;

	// Field widths
	localparam int OP_W      = 2;
	localparam int TOKEN_W   = 64;
	localparam int NOW_W     = 63;
	localparam int TIMEOUT_W = 40;
	localparam int EXPIRY_W  = 64;

	// Thirty minutes in microseconds
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(64'd1800000000);

	// Opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the request beat
		logic exec;    // update the table and load the result register
		logic cfg_wr;  // write the timeout register
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/tst_if.sv =====
// ----------------------------------------------------------------------------
// Session table channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tst_req_if;
	logic                         valid;
	logic                         ready;
	logic [tst_pkg::OP_W-1:0]     opcode;
	logic [tst_pkg::TOKEN_W-1:0]  token_high;
	logic [tst_pkg::TOKEN_W-1:0]  token_low;
	logic [tst_pkg::NOW_W-1:0]    now_us;

	modport source (output valid, opcode, token_high, token_low, now_us, input ready);
	modport sink   (input valid, opcode, token_high, token_low, now_us, output ready);
endinterface

interface tst_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            found;
	logic [tst_pkg::OUT_SLOT_W-1:0]  slot;
	logic                            evicted;
	logic                            expired;

	modport source (output valid, found, slot, evicted, expired, input ready);
	modport sink   (input valid, found, slot, evicted, expired, output ready);
endinterface

interface tst_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tst_pkg::TIMEOUT_W-1:0]  idle_timeout_us;

	modport source (output valid, idle_timeout_us, input ready);
	modport sink   (input valid, idle_timeout_us, output ready);
endinterface

`default_nettype wire

// ===== sv/timed_session_table.sv =====
// ----------------------------------------------------------------------------
// timed_session_table
// Four-slot session table with idle timeout: insert, check and remove.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | opcode, token_high, token_low, now_us
//  rsp     | out | valid / ready | found, slot, evicted, expired
//  cfg     | in  | valid / ready | idle_timeout_us
//
//  A request first has its beat captured and its deadline formed, then goes
//  through the parallel slot compares and the table write-back. A new
//  request is accepted only once the previous one has executed; a stalled
//  response holds the next request in its evaluate step.
//  Reset clears the valid bits and loads the thirty-minute timeout.
//  Configuration beats are accepted in every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timed_session_table (
	input  wire logic clk,
	input  wire logic arst_n,
	tst_req_if.sink   req,
	tst_rsp_if.source rsp,
	tst_cfg_if.sink   cfg
);

	tst_pkg::cmd_t cmd;

	tst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd)
	);

	tst_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (req.opcode),
		.token_high  (req.token_high),
		.token_low   (req.token_low),
		.now_us      (req.now_us),
		.cfg_timeout (cfg.idle_timeout_us),
		.found       (rsp.found),
		.slot        (rsp.slot),
		.evicted     (rsp.evicted),
		.expired     (rsp.expired)
	);

endmodule

`default_nettype wire

// ===== sv/tst_datapath.sv =====
// ----------------------------------------------------------------------------
// tst_datapath
// Session store, timeout register, parallel slot compares and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tst_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tst_pkg::cmd_t                     cmd,
	input  wire logic [tst_pkg::OP_W-1:0]          opcode,
	input  wire logic [tst_pkg::TOKEN_W-1:0]       token_high,
	input  wire logic [tst_pkg::TOKEN_W-1:0]       token_low,
	input  wire logic [tst_pkg::NOW_W-1:0]         now_us,
	input  wire logic [tst_pkg::TIMEOUT_W-1:0]     cfg_timeout,
	output logic                                   found,
	output logic [tst_pkg::OUT_SLOT_W-1:0]         slot,
	output logic                                   evicted,
	output logic                                   expired
);

	// Configuration and table state
	logic [tst_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [tst_pkg::SLOTS-1:0]     valid_q;
	logic [tst_pkg::TOKEN_W-1:0]   tok_hi_q [tst_pkg::SLOTS];
	logic [tst_pkg::TOKEN_W-1:0]   tok_lo_q [tst_pkg::SLOTS];
	logic [tst_pkg::EXPIRY_W-1:0]  exp_q    [tst_pkg::SLOTS];

	// Captured request beat
	logic [tst_pkg::OP_W-1:0]      op_q;
	logic [tst_pkg::TOKEN_W-1:0]   hi_q;
	logic [tst_pkg::TOKEN_W-1:0]   lo_q;
	logic [tst_pkg::NOW_W-1:0]     now_q;
	logic [tst_pkg::EXPIRY_W-1:0]  deadline_q;

	// Result register
	logic                          found_q;
	logic [tst_pkg::OUT_SLOT_W-1:0] slot_q;
	logic                          evicted_q;
	logic                          expired_q;

	// Per-slot compare results
	logic [tst_pkg::SLOTS-1:0]     match;
	logic [tst_pkg::SLOTS-1:0]     late;
	logic [tst_pkg::SLOTS-1:0]     oldest;
	logic [tst_pkg::SLOTS-1:0]     free_oh;
	logic [tst_pkg::SLOTS-1:0]     match_oh;
	logic                          free_any;
	logic                          match_any;
	logic                          match_late;
	logic [tst_pkg::SLOT_W-1:0]    free_idx;
	logic [tst_pkg::SLOT_W-1:0]    match_idx;
	logic [tst_pkg::SLOT_W-1:0]    oldest_idx;
	logic [tst_pkg::SLOT_W-1:0]    ins_idx;

	// Compare every slot in parallel
	always_comb begin
		for (int i = 0; i < tst_pkg::SLOTS; i++) begin
			match[i] = valid_q[i] && (tok_hi_q[i] == hi_q) && (tok_lo_q[i] == lo_q);
			late[i]  = {1'b0, now_q} > exp_q[i];
			oldest[i] = 1'b1;
			for (int j = 0; j < tst_pkg::SLOTS; j++) begin
				if (j < i && !(exp_q[i] < exp_q[j])) begin
					oldest[i] = 1'b0;
				end
				if (j > i && !(exp_q[i] <= exp_q[j])) begin
					oldest[i] = 1'b0;
				end
			end
		end
	end

	// Pick the lowest free and the lowest matching slot
	always_comb begin
		logic [tst_pkg::SLOTS-1:0] free_seen;
		logic [tst_pkg::SLOTS-1:0] match_seen;
		free_seen  = '0;
		match_seen = '0;
		for (int i = 0; i < tst_pkg::SLOTS; i++) begin
			free_oh[i]  = !valid_q[i] && (i == 0 || free_seen[(i > 0) ? i - 1 : 0] == 1'b0);
			match_oh[i] = match[i] && (i == 0 || match_seen[(i > 0) ? i - 1 : 0] == 1'b0);
			free_seen[i]  = !valid_q[i] || (i > 0 && free_seen[(i > 0) ? i - 1 : 0]);
			match_seen[i] = match[i] || (i > 0 && match_seen[(i > 0) ? i - 1 : 0]);
		end
		free_any  = |free_oh;
		match_any = |match_oh;
	end

	// Encode the one-hot choices
	always_comb begin
		free_idx   = '0;
		match_idx  = '0;
		oldest_idx = '0;
		for (int i = 0; i < tst_pkg::SLOTS; i++) begin
			free_idx   = free_idx   | ({tst_pkg::SLOT_W{free_oh[i]}}  & tst_pkg::SLOT_W'(i));
			match_idx  = match_idx  | ({tst_pkg::SLOT_W{match_oh[i]}} & tst_pkg::SLOT_W'(i));
			oldest_idx = oldest_idx | ({tst_pkg::SLOT_W{oldest[i]}}   & tst_pkg::SLOT_W'(i));
		end
		match_late = |(match_oh & late);
		ins_idx    = free_any ? free_idx : oldest_idx;
	end

	// Timeout register and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tst_pkg::TIMEOUT_RESET;
			valid_q   <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				timeout_q <= cfg_timeout;
			end
			if (cmd.exec) begin
				case (op_q) inside
					tst_pkg::OP_INSERT: begin
						valid_q[ins_idx] <= 1'b1;
					end
					tst_pkg::OP_CHECK: begin
						if (match_any && match_late) begin
							valid_q[match_idx] <= 1'b0;
						end
					end
					tst_pkg::OP_REMOVE: begin
						if (match_any) begin
							valid_q[match_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Capture the request beat and work out the new deadline
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= opcode;
			hi_q       <= token_high;
			lo_q       <= token_low;
			now_q      <= now_us;
			deadline_q <= {1'b0, now_us} + {{(tst_pkg::EXPIRY_W - tst_pkg::TIMEOUT_W){1'b0}},
				timeout_q};
		end
	end

	// Write tokens and expiries, load the result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			found_q   <= 1'b0;
			slot_q    <= '0;
			evicted_q <= 1'b0;
			expired_q <= 1'b0;
			case (op_q) inside
				tst_pkg::OP_INSERT: begin
					tok_hi_q[ins_idx] <= hi_q;
					tok_lo_q[ins_idx] <= lo_q;
					exp_q[ins_idx]    <= deadline_q;
					found_q           <= 1'b1;
					slot_q            <= tst_pkg::OUT_SLOT_W'(ins_idx);
					evicted_q         <= !free_any;
				end
				tst_pkg::OP_CHECK, tst_pkg::OP_REMOVE: begin
					if (match_any) begin
						if (match_late) begin
							expired_q <= 1'b1;
						end else begin
							found_q <= 1'b1;
							slot_q  <= tst_pkg::OUT_SLOT_W'(match_idx);
							if (op_q == tst_pkg::OP_CHECK) begin
								exp_q[match_idx] <= deadline_q;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign found   = found_q;
	assign slot    = slot_q;
	assign evicted = evicted_q;
	assign expired = expired_q;

endmodule

`default_nettype wire

// ===== sv/tst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tst_ctrl
// Controller: request capture, table update and response valid handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tst_ctrl (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tst_req_if.sink     req,
	tst_rsp_if.source   rsp,
	tst_cfg_if.sink     cfg,
	output tst_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   exec;

	// Configuration beats are always taken
	assign cfg.ready = 1'b1;

	// Accept a request beat only while idle
	assign req.ready = (state_q == ST_IDLE);

	// Execute once the result register is free
	assign exec = (state_q == ST_EVAL) && (!rsp_valid_q || rsp.ready);

	assign cmd.load   = req.valid && req.ready;
	assign cmd.exec   = exec;
	assign cmd.cfg_wr = cfg.valid;

	assign rsp.valid = rsp_valid_q;

	// Advance the state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	`TST_ASSERT_NXT(a_load_enters_eval, clk, arst_n, req.valid && req.ready, state_q == ST_EVAL)
	`TST_ASSERT_IMP(a_no_load_in_eval, clk, arst_n, state_q == ST_EVAL, !cmd.load)
	`TST_ASSERT_NXT(a_exec_gives_rsp, clk, arst_n, exec, rsp_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire

// ===== tb/timed_session_table_tb.sv =====
// ----------------------------------------------------------------------------
// timed_session_table_tb
// Drives insert, check and remove beats into the four-slot session table and
// compares every response with a cycle-free prediction of the table state.
// A short table of directed beats comes first: empty table, boundaries,
// duplicates, eviction, zero and maximum timeout. Random beats follow, drawn
// mostly from a small token pool with time advancing on the timeout scale.
// Both channel sides idle at random; the timeout is rewritten while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_session_table_tb;

	localparam logic [tst_pkg::OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [tst_pkg::NOW_W-1:0]     NOW_MAX   = {tst_pkg::NOW_W{1'b1}};
	localparam logic [tst_pkg::TIMEOUT_W-1:0] TMO_MAX   = {tst_pkg::TIMEOUT_W{1'b1}};
	localparam logic [63:0]                   T_RST     = 64'(tst_pkg::TIMEOUT_RESET);
	localparam int                            STALL_LIMIT = 4000;
	localparam int                            RAND_ITEMS  = 600;

	typedef struct packed {
		logic                           found;
		logic [tst_pkg::OUT_SLOT_W-1:0] slot;
		logic                           evicted;
		logic                           expired;
	} sess_rsp_t;

	typedef struct {
		bit                            is_cfg;
		logic [tst_pkg::TIMEOUT_W-1:0] cfg_val;
		logic [tst_pkg::OP_W-1:0]      op;
		logic [tst_pkg::TOKEN_W-1:0]   hi;
		logic [tst_pkg::TOKEN_W-1:0]   lo;
		logic [tst_pkg::NOW_W-1:0]     now;
		bit                            pinned;
		sess_rsp_t                     res;
	} req_row_t;

	typedef struct packed {
		bit        pinned;
		sess_rsp_t res;
	} pin_t;

	localparam sess_rsp_t RSP_NONE = '{found: 1'b0, slot: 2'd0, evicted: 1'b0, expired: 1'b0};
	localparam sess_rsp_t RSP_GONE = '{found: 1'b0, slot: 2'd0, evicted: 1'b0, expired: 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tst_req_if req_ch ();
	tst_rsp_if rsp_ch ();
	tst_cfg_if cfg_ch ();

	timed_session_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted table contents
	logic [tst_pkg::SLOTS-1:0]     slot_live;
	logic [tst_pkg::TOKEN_W-1:0]   tok_hi_tab [tst_pkg::SLOTS];
	logic [tst_pkg::TOKEN_W-1:0]   tok_lo_tab [tst_pkg::SLOTS];
	logic [tst_pkg::EXPIRY_W-1:0]  exp_tab    [tst_pkg::SLOTS];
	logic [tst_pkg::TIMEOUT_W-1:0] tmo_cur;

	sess_rsp_t rsp_q [$];
	pin_t      pin_q [$];
	req_row_t  dir_rows [$];

	int unsigned tx_idle = 22;
	int unsigned rx_idle = 63;
	int errors = 0;
	int n_sent = 0;
	int n_rsp = 0;
	int stall_cycles = 0;

	logic [tst_pkg::TOKEN_W-1:0] pool_hi [6];
	logic [tst_pkg::TOKEN_W-1:0] pool_lo [6];

	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic sess_rsp_t sess_hit(input int s, input bit ev);
		sess_rsp_t r;
		r = RSP_NONE;
		r.found = 1'b1;
		r.slot = tst_pkg::OUT_SLOT_W'(s);
		r.evicted = ev;
		return r;
	endfunction

	// Apply one request to the predicted table and return its response
	function automatic sess_rsp_t sess_predict(input logic [tst_pkg::OP_W-1:0] op,
			input logic [tst_pkg::TOKEN_W-1:0] hi, input logic [tst_pkg::TOKEN_W-1:0] lo,
			input logic [tst_pkg::NOW_W-1:0] now);
		sess_rsp_t r;
		logic [tst_pkg::EXPIRY_W-1:0] deadline;
		int s;
		r = RSP_NONE;
		deadline = {1'b0, now} + tst_pkg::EXPIRY_W'(tmo_cur);
		s = -1;
		case (op) inside
			tst_pkg::OP_INSERT: begin
				for (int i = 0; i < tst_pkg::SLOTS; i++)
					if (s < 0 && !slot_live[i]) s = i;
				// full table: oldest expiry goes, lowest index on a tie
				if (s < 0) begin
					s = 0;
					for (int i = 1; i < tst_pkg::SLOTS; i++)
						if (exp_tab[i] < exp_tab[s]) s = i;
					r.evicted = 1'b1;
				end
				slot_live[s] = 1'b1;
				tok_hi_tab[s] = hi;
				tok_lo_tab[s] = lo;
				exp_tab[s] = deadline;
				r.found = 1'b1;
				r.slot = tst_pkg::OUT_SLOT_W'(s);
			end
			tst_pkg::OP_CHECK, tst_pkg::OP_REMOVE: begin
				for (int i = 0; i < tst_pkg::SLOTS; i++)
					if (s < 0 && slot_live[i] && tok_hi_tab[i] == hi && tok_lo_tab[i] == lo)
						s = i;
				if (s >= 0) begin
					if ({1'b0, now} > exp_tab[s]) begin
						slot_live[s] = 1'b0;
						r.expired = 1'b1;
					end else begin
						r.found = 1'b1;
						r.slot = tst_pkg::OUT_SLOT_W'(s);
						if (op == tst_pkg::OP_CHECK)
							exp_tab[s] = deadline;
						else
							slot_live[s] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_req(input logic [tst_pkg::OP_W-1:0] op,
			input logic [tst_pkg::TOKEN_W-1:0] hi, input logic [tst_pkg::TOKEN_W-1:0] lo,
			input logic [tst_pkg::NOW_W-1:0] now, input bit pinned, input sess_rsp_t res);
		req_row_t r;
		r.is_cfg = 1'b0;
		r.cfg_val = '0;
		r.op = op;
		r.hi = hi;
		r.lo = lo;
		r.now = now;
		r.pinned = pinned;
		r.res = res;
		dir_rows.push_back(r);
	endtask

	task automatic add_cfg(input logic [tst_pkg::TIMEOUT_W-1:0] val);
		req_row_t r;
		r.is_cfg = 1'b1;
		r.cfg_val = val;
		r.op = OP_UNUSED;
		r.hi = '0;
		r.lo = '0;
		r.now = '0;
		r.pinned = 1'b0;
		r.res = RSP_NONE;
		dir_rows.push_back(r);
	endtask

	// Send one request beat, idling first at random; returns at the accepting edge
	task automatic send_req(input req_row_t r);
		bit lowered;
		lowered = 1'b0;
		while ($urandom_range(99) < tx_idle) begin
			if (!lowered) begin
				req_ch.valid <= 1'b0;
				lowered = 1'b1;
			end
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= r.op;
		req_ch.token_high <= r.hi;
		req_ch.token_low  <= r.lo;
		req_ch.now_us     <= r.now;
		pin_q.push_back('{pinned: r.pinned, res: r.res});
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		n_sent++;
	endtask

	// Write the timeout once every response has drained
	task automatic write_timeout(input logic [tst_pkg::TIMEOUT_W-1:0] val);
		req_ch.valid <= 1'b0;
		while (n_rsp != n_sent) @(posedge clk);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.idle_timeout_us <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	// Fresh token pool; some entries share one half with another
	task automatic new_pool();
		for (int i = 0; i < 6; i++) begin
			pool_hi[i] = rand64();
			pool_lo[i] = rand64();
		end
		pool_hi[3] = pool_hi[0];
		pool_lo[4] = pool_lo[1];
	endtask

	// Receiver: drop ready at random
	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle);

	// Check response beats, predict request beats, track the timeout
	always @(posedge clk) begin : monitor
		sess_rsp_t got;
		sess_rsp_t want;
		sess_rsp_t pred;
		pin_t pin;
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = '{found: rsp_ch.found, slot: rsp_ch.slot,
					evicted: rsp_ch.evicted, expired: rsp_ch.expired};
				n_rsp++;
				if (rsp_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected beat: found=%0d slot=%0d evicted=%0d expired=%0d",
							got.found, got.slot, got.evicted, got.expired);
					errors++;
				end else begin
					want = rsp_q.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("mismatch at %0t: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime, want.found, want.slot, want.evicted, want.expired,
								got.found, got.slot, got.evicted, got.expired);
						errors++;
					end
				end
			end
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
				pred = sess_predict(req_ch.opcode, req_ch.token_high, req_ch.token_low,
					req_ch.now_us);
				pin = pin_q.pop_front();
				rsp_q.push_back(pin.pinned ? pin.res : pred);
			end
			if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
				tmo_cur = cfg_ch.idle_timeout_us;
		end
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timed_session_table_tb NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		req_row_t r;
		logic [tst_pkg::TIMEOUT_W-1:0] phase_tmo;
		logic [63:0] cur_now;
		logic [63:0] span;
		logic [63:0] step;
		logic [63:0] raw;
		int k;
		int idx;

		req_ch.valid           <= 1'b0;
		req_ch.opcode          <= tst_pkg::OP_INSERT;
		req_ch.token_high      <= '0;
		req_ch.token_low       <= '0;
		req_ch.now_us          <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.idle_timeout_us <= '0;
		slot_live = '0;
		tmo_cur = tst_pkg::TIMEOUT_RESET;
		for (int i = 0; i < tst_pkg::SLOTS; i++) begin
			tok_hi_tab[i] = '0;
			tok_lo_tab[i] = '0;
			exp_tab[i] = '0;
		end

		// Empty table, unused opcode, fill from the lowest slot
		add_req(tst_pkg::OP_CHECK,  '0, '0, '0, 1'b1, RSP_NONE);
		add_req(tst_pkg::OP_REMOVE, '0, '0, '0, 1'b1, RSP_NONE);
		add_req(OP_UNUSED, '1, '1, NOW_MAX, 1'b1, RSP_NONE);
		add_req(tst_pkg::OP_INSERT, '0, '0, '0, 1'b1, sess_hit(0, 1'b0));
		add_req(tst_pkg::OP_INSERT, '1, '1, NOW_MAX, 1'b1, sess_hit(1, 1'b0));
		add_req(tst_pkg::OP_INSERT, '1, '0, 63'd1000, 1'b1, sess_hit(2, 1'b0));
		add_req(tst_pkg::OP_INSERT, '0, '0, 63'd2000, 1'b1, sess_hit(3, 1'b0));
		// Live at the boundary, then both duplicates expire in order
		add_req(tst_pkg::OP_CHECK,  '0, '0, 63'(T_RST), 1'b1, sess_hit(0, 1'b0));
		add_req(tst_pkg::OP_CHECK,  '0, '0, 63'(2 * T_RST + 1), 1'b1, RSP_GONE);
		add_req(tst_pkg::OP_CHECK,  '0, '0, 63'(2 * T_RST + 1), 1'b1, RSP_GONE);
		add_req(tst_pkg::OP_CHECK,  '0, '0, '0, 1'b1, RSP_NONE);
		add_req(tst_pkg::OP_INSERT, '0, '1, 63'd5, 1'b1, sess_hit(0, 1'b0));
		add_req(tst_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 64'd1, 63'd6, 1'b1,
			sess_hit(3, 1'b0));
		// Full table: evict the oldest expiry
		add_req(tst_pkg::OP_INSERT, 64'd1, 64'h8000_0000_0000_0000, 63'd7, 1'b1,
			sess_hit(0, 1'b1));
		add_req(tst_pkg::OP_REMOVE, '1, '0, 63'(T_RST + 1000), 1'b1, sess_hit(2, 1'b0));
		add_req(tst_pkg::OP_REMOVE, '1, '0, '0, 1'b1, RSP_NONE);
		// Zero timeout: expiry equals now
		add_cfg('0);
		add_req(tst_pkg::OP_INSERT, '1, '0, 63'd50, 1'b0, RSP_NONE);
		add_req(tst_pkg::OP_CHECK,  '1, '0, 63'd50, 1'b0, RSP_NONE);
		add_req(tst_pkg::OP_CHECK,  '1, '0, 63'd51, 1'b0, RSP_NONE);
		// Largest timeout on the largest time
		add_cfg(TMO_MAX);
		add_req(tst_pkg::OP_INSERT, '0, '0, NOW_MAX, 1'b0, RSP_NONE);
		add_req(tst_pkg::OP_INSERT, '1, '1, '0, 1'b0, RSP_NONE);
		add_req(tst_pkg::OP_CHECK,  '1, '1, NOW_MAX, 1'b0, RSP_NONE);
		add_req(tst_pkg::OP_REMOVE, '0, '0, NOW_MAX, 1'b0, RSP_NONE);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_timeout(dir_rows[i].cfg_val);
			else
				send_req(dir_rows[i]);
		end

		// Random phases: receiver-heavy idling, sender-heavy, then none
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 22 : (ph == 1) ? 63 : 0;
			rx_idle = (ph == 0) ? 63 : (ph == 1) ? 22 : 0;
			new_pool();
			cur_now = 64'($urandom);
			phase_tmo = '0;
			for (int n = 0; n < RAND_ITEMS; n++) begin
				if (n % 150 == 0) begin
					raw = rand64();
					case ($urandom_range(5))
						0: phase_tmo = '0;
						1: phase_tmo = 40'd1;
						2: phase_tmo = TMO_MAX;
						3: phase_tmo = 40'($urandom_range(5000, 1));
						4: phase_tmo = raw[tst_pkg::TIMEOUT_W-1:0];
						default: phase_tmo = tst_pkg::TIMEOUT_RESET;
					endcase
					write_timeout(phase_tmo);
				end
				r.is_cfg = 1'b0;
				r.cfg_val = '0;
				r.pinned = 1'b0;
				r.res = RSP_NONE;
				k = $urandom_range(99);
				r.op = (k < 34) ? tst_pkg::OP_INSERT : (k < 68) ? tst_pkg::OP_CHECK :
					(k < 94) ? tst_pkg::OP_REMOVE : OP_UNUSED;
				// Mostly pool tokens, some noise
				if ($urandom_range(99) < 85) begin
					idx = $urandom_range(5);
					r.hi = pool_hi[idx];
					r.lo = pool_lo[idx];
				end else begin
					r.hi = rand64();
					r.lo = rand64();
				end
				// Advance time on the timeout scale, sometimes past it
				span = 64'(phase_tmo) / 2 + 2;
				step = rand64() % span;
				if ($urandom_range(99) < 6)
					step = 64'(phase_tmo) + 1 + 64'($urandom_range(3));
				cur_now = cur_now + step;
				if (cur_now[62])
					cur_now = 64'($urandom);
				r.now = cur_now[tst_pkg::NOW_W-1:0];
				k = $urandom_range(99);
				raw = rand64();
				if (k < 5)
					r.now = raw[tst_pkg::NOW_W-1:0];
				else if (k < 7)
					r.now = NOW_MAX - tst_pkg::NOW_W'($urandom_range(3));
				send_req(r);
			end
		end

		// Drain and let the block settle
		req_ch.valid <= 1'b0;
		while (n_rsp != n_sent) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && rsp_q.size() == 0)
			$display("timed_session_table_tb OK");
		else
			$display("timed_session_table_tb NOT OK");
		$finish;
	end

endmodule
